>>> rtl/vdof_pkg.sv
package vdof_pkg;

  // voxel table geometry
  localparam int unsigned TABLE_SLOTS = 4096;
  localparam int unsigned SLOT_BITS   = $clog2(TABLE_SLOTS);

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_COUNT    = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_PARAM = 2'd2,
    ST_NONFINITE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_SIZE_X     = 2'd0,
    REG_SIZE_Y     = 2'd1,
    REG_SIZE_Z     = 2'd2,
    REG_MIN_POINTS = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_DIV_START,
    S_DIV_WAIT,
    S_HASH,
    S_READ,
    S_CHECK,
    S_WRITE,
    S_OUT
  } state_e;

  // divider handshake
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

>>> rtl/vdof_divider.sv
// Restoring divider, one quotient bit per cycle; floor division of a signed
// dividend by an unsigned divisor, clamped to IndexBits-bit signed.
module vdof_divider #(
  parameter int unsigned IndexBits = 21
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [31:0]              dividend_i,
  input  logic [31:0]              divisor_i,
  output vdof_pkg::div_ctl_t       ctl_o,
  output logic [IndexBits-1:0]     index_o
);
  import vdof_pkg::*;

  localparam int unsigned CntW = 6;

  logic [31:0]     mag_q, mag_d;
  logic [32:0]     rem_q, rem_d;
  logic [31:0]     quo_q, quo_d;
  logic [31:0]     div_q, div_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [32:0]     trial;

  // magnitude of the dividend on start, then the restoring shift-subtract steps while busy
  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], mag_q[31]} - {1'b0, div_q};
    if (start_i) begin
      neg_d  = dividend_i[31];
      mag_d  = dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;
      rem_d  = '0;
      quo_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CntW'(32);
      busy_d = 1'b1;
    end else if (busy_q) begin
      mag_d = {mag_q[30:0], 1'b0};
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], mag_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  // round the magnitude up for negatives (floor), then clamp
  localparam logic [33:0] HiLim = 34'((64'd1 << (IndexBits - 1)) - 64'd1);
  localparam logic [33:0] LoMag = 34'(64'd1 << (IndexBits - 1));
  logic [33:0] qmag;
  logic [IndexBits-1:0] idx;
  always_comb begin
    qmag = {2'b00, quo_q} + ((neg_q && rem_q != '0) ? 34'd1 : 34'd0);
    if (!neg_q) begin
      idx = (qmag > HiLim) ? IndexBits'(HiLim) : qmag[IndexBits-1:0];
    end else if (qmag >= LoMag) begin
      idx = IndexBits'(LoMag);
    end else begin
      idx = IndexBits'(~qmag + 34'd1);
    end
  end

  assign index_o    = idx;
  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;
endmodule

>>> rtl/vdof_table.sv
// Valid, key and count memory with registered read.
module vdof_table #(
  parameter int unsigned SlotBits = 12,
  parameter int unsigned KeyW     = 63
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [SlotBits-1:0] addr_i,
  input  logic                wvld_i,
  input  logic [KeyW-1:0]     wkey_i,
  input  logic [15:0]         wcnt_i,
  output logic                rvld_o,
  output logic [KeyW-1:0]     rkey_o,
  output logic [15:0]         rcnt_o
);
  logic            vlds [2**SlotBits];
  logic [KeyW-1:0] keys [2**SlotBits];
  logic [15:0]     cnts [2**SlotBits];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      vlds[addr_i] <= wvld_i;
      keys[addr_i] <= wkey_i;
      cnts[addr_i] <= wcnt_i;
    end
    rvld_o <= vlds[addr_i];
    rkey_o <= keys[addr_i];
    rcnt_o <= cnts[addr_i];
  end
endmodule

>>> rtl/voxel_density_outlier_filter.sv
// Voxel density outlier filter. Each item carries an opcode: clear empties
// the voxel table, count bins the point (floor(coordinate / size) per axis,
// clamped) and increments its voxel in a linear-probing hash table of
// TABLE_SLOTS entries, classify reports whether the voxel count reaches
// min_points. One result per item. Per item the one shared 32-step divider
// runs three times, once per axis; the hash then gives the first slot, each
// probe of the single-port table memory reads and checks one slot, a count
// that finds its voxel or an empty slot writes it, and the result register
// is loaded. Rejected items (unused opcode, invalid parameters, non-finite
// point) go straight to the result register. A clear sweeps the valid bits
// of all TABLE_SLOTS entries, one per cycle; the same sweep runs after
// reset, with ready low until it ends. Ready is low while an item is in
// work; a finished result waits in the output register, so the next item
// can be taken while it is pending.
module voxel_density_outlier_filter #(
  parameter int unsigned IndexBits  = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [103:0] s_axis_tdata_i, // opcode, point_x, point_y, point_z, finite
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // keep, status, voxel_count
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import vdof_pkg::*;

  localparam int unsigned SlotBits = SLOT_BITS;
  localparam int unsigned KeyW     = 3 * IndexBits;

  // registers
  logic [31:0] size_x_q, size_y_q, size_z_q;
  logic [15:0] min_q;
  logic        pwr;
  reg_e        ridx;
  assign ridx     = reg_e'(paddr_i[3:2]);
  assign pwr      = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= 32'd65536;
      size_y_q <= 32'd65536;
      size_z_q <= 32'd65536;
      min_q    <= 16'd2;
    end else if (pwr) begin
      case (ridx)
        REG_SIZE_X:     size_x_q <= pwdata_i;
        REG_SIZE_Y:     size_y_q <= pwdata_i;
        REG_SIZE_Z:     size_z_q <= pwdata_i;
        REG_MIN_POINTS: min_q    <= pwdata_i[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_SIZE_X:     prdata_o = size_x_q;
      REG_SIZE_Y:     prdata_o = size_y_q;
      REG_SIZE_Z:     prdata_o = size_z_q;
      REG_MIN_POINTS: prdata_o = {16'd0, min_q};
      default:        prdata_o = '0;
    endcase
  end

  // input fields
  logic [1:0]  in_op;
  logic [31:0] in_x, in_y, in_z;
  logic        in_fin;
  assign in_op  = s_axis_tdata_i[1:0];
  assign in_x   = s_axis_tdata_i[33:2];
  assign in_y   = s_axis_tdata_i[65:34];
  assign in_z   = s_axis_tdata_i[97:66];
  assign in_fin = s_axis_tdata_i[98];

  state_e state_q, state_d;
  opcode_e op_q;
  logic [31:0] px_q, py_q, pz_q;
  logic [1:0]  axis_q;
  logic [IndexBits-1:0] kx_q, ky_q, kz_q;
  logic [SlotBits-1:0]  pos_q;
  logic [SlotBits-1:0]  clr_q;
  logic [SlotBits:0]    probes_q;
  logic [SlotBits:0]    used_q;
  logic        keep_q;
  status_e     status_q;
  logic [15:0] count_q;
  logic [18:0] res_q;
  logic        ovalid_q;

  // shared divider
  div_ctl_t div_ctl;
  logic [IndexBits-1:0] div_idx;
  logic [31:0] div_num, div_den;
  logic div_start;
  always_comb begin
    case (axis_q)
      2'd0:    begin div_num = px_q; div_den = size_x_q; end
      2'd1:    begin div_num = py_q; div_den = size_y_q; end
      default: begin div_num = pz_q; div_den = size_z_q; end
    endcase
  end
  assign div_start = (state_q == S_DIV_START);

  vdof_divider #(.IndexBits(IndexBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_num),
    .divisor_i(div_den), .ctl_o(div_ctl), .index_o(div_idx)
  );

  // table; the sweep writes invalid entries after reset and on clear
  logic [KeyW-1:0] key, rkey;
  logic [15:0] rcnt, wcnt;
  logic [SlotBits-1:0] tab_addr;
  logic we, wvld, rvld, sweep;
  assign key      = {kz_q, ky_q, kx_q};
  assign sweep    = (state_q == S_INIT) || (state_q == S_CLEAR);
  assign tab_addr = sweep ? clr_q : pos_q;
  vdof_table #(.SlotBits(SlotBits), .KeyW(KeyW)) u_tab (
    .clk_i, .we_i(we), .addr_i(tab_addr), .wvld_i(wvld), .wkey_i(key), .wcnt_i(wcnt),
    .rvld_o(rvld), .rkey_o(rkey), .rcnt_o(rcnt)
  );

  logic [KeyW-1:0] hash;
  assign hash = {{(2*IndexBits){1'b0}}, kx_q}
              ^ {{(2*IndexBits-1){1'b0}}, ky_q, 1'b0}
              ^ {{(2*IndexBits-2){1'b0}}, kz_q, 2'b0};

  logic accept, bad_param, slot_v, hit, found_q, sweep_last, out_load;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign bad_param = size_x_q == '0 || size_y_q == '0 || size_z_q == '0 || min_q == '0;
  assign slot_v    = rvld;
  assign hit       = slot_v && rkey == key;
  assign sweep_last = (clr_q == SlotBits'(TABLE_SLOTS - 1));
  assign out_load  = (state_q == S_OUT) && (!ovalid_q || m_axis_tready_i);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign we   = (state_q == S_WRITE) || sweep;
  assign wvld = (state_q == S_WRITE);
  assign wcnt = found_q ? ((rcnt == 16'hFFFF) ? rcnt : rcnt + 16'd1) : 16'd1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:      if (sweep_last) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (opcode_e'(in_op) == OP_CLEAR) state_d = S_CLEAR;
          else if (opcode_e'(in_op) == OP_UNUSED || bad_param || !in_fin) state_d = S_OUT;
          else state_d = S_DIV_START;
        end
      end
      S_CLEAR:     if (sweep_last) state_d = S_OUT;
      S_DIV_START: state_d = S_DIV_WAIT;
      S_DIV_WAIT:  if (div_ctl.done) state_d = (axis_q == 2'd2) ? S_HASH : S_DIV_START;
      S_HASH:      state_d = S_READ;
      S_READ:      state_d = S_CHECK;
      S_CHECK: begin
        if (!slot_v || hit) state_d = (op_q == OP_COUNT) ? S_WRITE : S_OUT;
        else if (probes_q == (SlotBits+1)'(TABLE_SLOTS - 1)) state_d = S_OUT;
        else state_d = S_READ;
      end
      S_WRITE: state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      clr_q    <= '0;
      used_q   <= '0;
      ovalid_q <= 1'b0;
      axis_q   <= '0;
    end else begin
      state_q <= state_d;
      if (sweep) clr_q <= clr_q + SlotBits'(1);
      if (out_load) ovalid_q <= 1'b1;
      else if (m_axis_tvalid_o && m_axis_tready_i) ovalid_q <= 1'b0;
      if (state_q == S_CLEAR) used_q <= '0;
      else if (state_q == S_WRITE && !found_q) used_q <= used_q + (SlotBits+1)'(1);
      if (accept) axis_q <= 2'd0;
      else if (state_q == S_DIV_WAIT && div_ctl.done) axis_q <= axis_q + 2'd1;
    end
  end

  // datapath and result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= opcode_e'(in_op);
      px_q     <= in_x;
      py_q     <= in_y;
      pz_q     <= in_z;
      keep_q   <= 1'b0;
      count_q  <= '0;
      found_q  <= 1'b0;
      probes_q <= '0;
      if (opcode_e'(in_op) == OP_CLEAR || opcode_e'(in_op) == OP_UNUSED) status_q <= ST_OK;
      else if (bad_param) status_q <= ST_BAD_PARAM;
      else if (!in_fin) status_q <= ST_NONFINITE;
      else status_q <= ST_OK;
    end
    if (state_q == S_DIV_WAIT && div_ctl.done) begin
      case (axis_q)
        2'd0:    kx_q <= div_idx;
        2'd1:    ky_q <= div_idx;
        default: kz_q <= div_idx;
      endcase
    end
    if (state_q == S_HASH) pos_q <= hash[SlotBits-1:0];
    if (state_q == S_CHECK) begin
      if (hit) begin
        found_q <= 1'b1;
        if (op_q == OP_CLASSIFY) begin
          count_q <= rcnt;
          keep_q  <= rcnt >= min_q;
        end
      end else if (slot_v) begin
        pos_q    <= pos_q + SlotBits'(1);
        probes_q <= probes_q + (SlotBits+1)'(1);
        if (probes_q == (SlotBits+1)'(TABLE_SLOTS - 1) && op_q == OP_COUNT)
          status_q <= ST_FULL;
      end
    end
    if (state_q == S_WRITE) count_q <= wcnt;
    if (out_load) res_q <= {count_q, status_q, keep_q};
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {5'd0, res_q};

  // checks
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while pending");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= (SlotBits+1)'(TABLE_SLOTS))
    else $error("slot count overflow");
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> sweep || op_q == OP_COUNT)
    else $error("table write outside count");
  a_keep_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> status_e'(m_axis_tdata_o[2:1]) == ST_OK)
    else $error("keep with error status");
endmodule

>>> dv/voxel_density_outlier_filter_tb.sv
module voxel_density_outlier_filter_tb;
  import vdof_pkg::*;

  localparam int unsigned SLOTS      = 4096;
  localparam int unsigned IDX_W      = 21;
  localparam int unsigned STALL_MAX  = 20000;
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned RUN_LEN    = 160;

  typedef struct {
    opcode_e     op;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        fin;
    bit          typed;   // expected value given in the row
    logic        keep;
    status_e     st;
    logic [15:0] cnt;
  } point_item_t;

  typedef struct {
    logic        keep;
    status_e     st;
    logic [15:0] cnt;
  } verdict_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i;  // opcode, point_x, point_y, point_z, finite
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [23:0]  m_axis_tdata_o;  // keep, status, voxel_count
  logic         psel_i;
  logic         penable_i;
  logic         pwrite_i;
  logic [3:0]   paddr_i;
  logic [31:0]  pwdata_i;
  logic [31:0]  prdata_o;
  logic         pready_o;

  voxel_density_outlier_filter u_top (.*);

  // mirror of the voxel table and registers
  logic [62:0]  key_mem [SLOTS];
  bit           slot_vld [SLOTS];
  logic [15:0]  cnt_mem [SLOTS];
  logic [31:0]  cfg_size [3];
  logic [15:0]  cfg_min;

  verdict_t     verdicts_due [$];
  int unsigned  n_err;
  int unsigned  stall_cnt;
  bit           src_fast;
  bit           sink_fast;
  bit           hold_long;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // floor(p / size), clamped to the signed index range
  function automatic logic [IDX_W-1:0] voxel_axis(logic [31:0] raw, logic [31:0] sz);
    longint p;
    longint s;
    longint q;
    p = longint'(signed'(raw));
    s = longint'({32'b0, sz});
    if (p >= 0) q = p / s;
    else q = -((-p + s - 1) / s);
    if (q < -(longint'(1) << (IDX_W - 1))) q = -(longint'(1) << (IDX_W - 1));
    if (q > (longint'(1) << (IDX_W - 1)) - 1) q = (longint'(1) << (IDX_W - 1)) - 1;
    return q[IDX_W-1:0];
  endfunction

  // applies one item to the mirror table and returns its result
  function automatic verdict_t voxel_update(point_item_t it);
    verdict_t        v;
    logic [IDX_W-1:0] kx, ky, kz;
    logic [62:0]     key;
    logic [22:0]     h;
    int unsigned     pos, empty_at;
    bit              found;
    v = '{1'b0, ST_OK, 16'd0};
    if (it.op == OP_CLEAR) begin
      foreach (slot_vld[i]) slot_vld[i] = 1'b0;
    end else if (it.op != OP_UNUSED) begin
      if (cfg_size[0] == 0 || cfg_size[1] == 0 || cfg_size[2] == 0 || cfg_min == 0) begin
        v.st = ST_BAD_PARAM;
      end else if (!it.fin) begin
        v.st = ST_NONFINITE;
      end else begin
        kx = voxel_axis(it.x, cfg_size[0]);
        ky = voxel_axis(it.y, cfg_size[1]);
        kz = voxel_axis(it.z, cfg_size[2]);
        key = {kz, ky, kx};
        h = {2'b0, kx} ^ {1'b0, ky, 1'b0} ^ {kz, 2'b0};
        pos = h % SLOTS;
        empty_at = SLOTS;
        found = 1'b0;
        for (int n = 0; n < SLOTS; n++) begin
          if (!slot_vld[pos]) begin
            empty_at = pos;
            break;
          end
          if (key_mem[pos] == key) begin
            found = 1'b1;
            break;
          end
          pos = (pos + 1) % SLOTS;
        end
        if (it.op == OP_COUNT) begin
          if (found) begin
            if (cnt_mem[pos] != 16'hFFFF) cnt_mem[pos]++;
            v.cnt = cnt_mem[pos];
          end else if (empty_at < SLOTS) begin
            slot_vld[empty_at] = 1'b1;
            key_mem[empty_at] = key;
            cnt_mem[empty_at] = 16'd1;
            v.cnt = 16'd1;
          end else begin
            v.st = ST_FULL;
          end
        end else if (found) begin
          v.cnt = cnt_mem[pos];
          v.keep = (cnt_mem[pos] >= cfg_min);
        end
      end
    end
    return v;
  endfunction

  // APB write: setup cycle, then access cycle
  task automatic reg_write(reg_e idx, logic [31:0] val);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= 4'(idx) << 2;
    pwdata_i  <= val;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    if (idx == REG_MIN_POINTS) cfg_min = val[15:0];
    else cfg_size[int'(idx)] = val;
  endtask

  task automatic set_config(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                            logic [15:0] mp);
    reg_write(REG_SIZE_X, sx);
    reg_write(REG_SIZE_Y, sy);
    reg_write(REG_SIZE_Z, sz);
    reg_write(REG_MIN_POINTS, {16'b0, mp});
  endtask

  // all results in, then a few spare cycles before touching registers
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_point(point_item_t it);
    int unsigned gap;
    verdict_t    v;
    gap = src_fast ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b0, it.fin, it.z, it.y, it.x, it.op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    v = voxel_update(it);
    if (it.typed) v = '{it.keep, it.st, it.cnt};
    verdicts_due = {verdicts_due, v};
  endtask

  function automatic point_item_t mk_point(opcode_e op, logic [31:0] x, logic [31:0] y,
                                           logic [31:0] z, logic fin);
    return '{op, x, y, z, fin, 1'b0, 1'b0, ST_OK, 16'd0};
  endfunction

  function automatic point_item_t mk_typed(opcode_e op, logic [31:0] x, logic fin,
                                           logic k, status_e st, logic [15:0] c);
    return '{op, x, 32'd0, 32'd0, fin, 1'b1, k, st, c};
  endfunction

  // result checker with random back-pressure
  initial begin
    verdict_t    e;
    verdict_t    got;
    int unsigned gap;
    int unsigned n_res;
    n_res = 0;
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_long) begin
        gap = LONG_HOLD;
        hold_long = 1'b0;
      end else begin
        gap = sink_fast ? 0 : $urandom_range(0, 10);
      end
      n_res++;
      if (n_res % 40 == 0) sink_fast = ($urandom_range(0, 3) == 0);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got = '{m_axis_tdata_o[0], status_e'(m_axis_tdata_o[2:1]), m_axis_tdata_o[18:3]};
      if (verdicts_due.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result: keep %0d status %s count %0d",
                                  got.keep, got.st.name(), got.cnt);
      end else begin
        e = verdicts_due.pop_front();
        if (got.keep !== e.keep || got.st !== e.st || got.cnt !== e.cnt) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: expected keep %0d status %s count %0d, got %0d %s %0d",
                     e.keep, e.st.name(), e.cnt, got.keep, got.st.name(), got.cnt);
        end
      end
    end
  end

  // stall watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cnt <= 0;
    end else if ((s_axis_tvalid_i && s_axis_tready_o) ||
                 (m_axis_tvalid_o && m_axis_tready_i) || psel_i) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("** voxel_density_outlier_filter: FAILED **");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    point_item_t dir_rows [14];
    point_item_t pts [$];
    point_item_t p;
    logic [31:0] pool [8][3];
    int unsigned n_pts;

    n_err = 0;
    src_fast = 1'b0;
    sink_fast = 1'b0;
    hold_long = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    psel_i = 1'b0;
    penable_i = 1'b0;
    pwrite_i = 1'b0;
    paddr_i = '0;
    pwdata_i = '0;
    cfg_size = '{32'd65536, 32'd65536, 32'd65536};
    cfg_min = 16'd2;
    foreach (slot_vld[i]) slot_vld[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items at reset settings
    dir_rows = '{
      mk_typed(OP_CLASSIFY, 32'd0, 1'b1, 1'b0, ST_OK, 16'd0),
      mk_typed(OP_COUNT, 32'd0, 1'b1, 1'b0, ST_OK, 16'd1),
      mk_typed(OP_COUNT, 32'h0000_8000, 1'b1, 1'b0, ST_OK, 16'd2),
      mk_typed(OP_CLASSIFY, 32'd0, 1'b1, 1'b1, ST_OK, 16'd2),
      mk_point(OP_COUNT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1),
      mk_point(OP_COUNT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1),
      mk_point(OP_CLASSIFY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1),
      mk_point(OP_COUNT, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1),
      mk_typed(OP_COUNT, 32'd0, 1'b0, 1'b0, ST_NONFINITE, 16'd0),
      mk_typed(OP_CLASSIFY, 32'd5, 1'b0, 1'b0, ST_NONFINITE, 16'd0),
      mk_typed(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_OK, 16'd0),
      mk_typed(OP_CLEAR, 32'd0, 1'b1, 1'b0, ST_OK, 16'd0),
      mk_typed(OP_CLASSIFY, 32'd0, 1'b1, 1'b0, ST_OK, 16'd0),
      mk_point(OP_COUNT, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFE_FFFF, 1'b1)
    };
    foreach (dir_rows[i]) send_point(dir_rows[i]);

    // invalid parameters win over the finite test
    drain();
    reg_write(REG_SIZE_Z, 32'd0);
    send_point(mk_typed(OP_COUNT, 32'd0, 1'b1, 1'b0, ST_BAD_PARAM, 16'd0));
    send_point(mk_typed(OP_CLASSIFY, 32'd0, 1'b0, 1'b0, ST_BAD_PARAM, 16'd0));
    drain();
    set_config(32'd65536, 32'd65536, 32'd65536, 16'd0);
    send_point(mk_typed(OP_CLASSIFY, 32'd0, 1'b1, 1'b0, ST_BAD_PARAM, 16'd0));
    drain();

    // fill a run of consecutive hashes, then probe across it and past the last slot
    set_config(32'd1, 32'd1, 32'd1, 16'hFFFF);
    src_fast = 1'b1;
    send_point(mk_point(OP_CLEAR, 32'd0, 32'd0, 32'd0, 1'b1));
    for (int i = 0; i < RUN_LEN; i++)
      send_point(mk_point(OP_COUNT, 32'(i), 32'd0, 32'd0, 1'b1));
    send_point(mk_point(OP_COUNT, 32'd2, 32'd1, 32'd0, 1'b1));
    send_point(mk_point(OP_CLASSIFY, 32'd2, 32'd1, 32'd0, 1'b1));
    send_point(mk_point(OP_COUNT, 32'd4095, 32'd0, 32'd0, 1'b1));
    send_point(mk_point(OP_COUNT, 32'd8191, 32'd0, 32'd0, 1'b1));
    send_point(mk_point(OP_COUNT, 32'd7, 32'd0, 32'd0, 1'b1));
    send_point(mk_point(OP_CLASSIFY, 32'd7, 32'd0, 32'd0, 1'b1));
    send_point(mk_typed(OP_CLEAR, 32'd0, 1'b1, 1'b0, ST_OK, 16'd0));
    src_fast = 1'b0;

    // random passes: clear, count a cloud, classify it, with noise mixed in
    for (int seg = 0; seg < 8; seg++) begin
      drain();
      case (seg)
        0: set_config(32'd65536, 32'd65536, 32'd65536, 16'd2);
        1: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
        2: set_config(32'd1, 32'd1, 32'd1, 16'd2);
        3: set_config(32'd1, 32'hFFFF_FFFF, 32'd65536, 16'd65535);
        default: set_config($urandom_range(1, 32'h0004_0000), $urandom_range(1, 32'h0004_0000),
                            $urandom_range(1, 32'h0004_0000), 16'($urandom_range(1, 5)));
      endcase
      if (seg == 1) hold_long = 1'b1;
      src_fast = ($urandom_range(0, 2) == 0);
      foreach (pool[i, j]) pool[i][j] = $urandom;
      pts.delete();
      n_pts = $urandom_range(50, 80);
      for (int i = 0; i < n_pts; i++) begin
        if ($urandom_range(0, 9) < 8) begin
          int unsigned c;
          c = $urandom_range(0, 7);
          p = mk_point(OP_COUNT, pool[c][0] + $urandom_range(0, 3),
                       pool[c][1] + $urandom_range(0, 3),
                       pool[c][2] + $urandom_range(0, 3), 1'b1);
        end else begin
          p = mk_point(OP_COUNT, $urandom, $urandom, $urandom, 1'b1);
        end
        if ($urandom_range(0, 19) == 0) p.fin = 1'b0;
        pts = {pts, p};
      end
      send_point(mk_point(OP_CLEAR, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1))));
      for (int pass = 0; pass < 2; pass++) begin
        foreach (pts[i]) begin
          p = pts[i];
          p.op = pass ? OP_CLASSIFY : OP_COUNT;
          if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
              0: p.op = OP_UNUSED;
              1: p.op = opcode_e'($urandom_range(1, 2));
              2: p.fin = ~p.fin;
              default: p.op = OP_CLEAR;
            endcase
          end
          send_point(p);
        end
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (n_err == 0) begin
      $display("** voxel_density_outlier_filter: PASSED **");
    end else begin
      $display("** voxel_density_outlier_filter: FAILED **");
    end
    $finish;
  end

endmodule

>>> voxel_density_outlier_filter.f
rtl/vdof_pkg.sv
rtl/vdof_divider.sv
rtl/vdof_table.sv
rtl/voxel_density_outlier_filter.sv
dv/voxel_density_outlier_filter_tb.sv
